// File: src/mrce_pkg.sv
// Shared constants and interface types of the Manhattan ring cell enumerator.
`default_nettype none

package mrce_pkg;

  // Largest grid edge; the effective row and column counts are clamped to it
  localparam int unsigned MaxDim   = 256;
  localparam int unsigned DimW     = $clog2(MaxDim + 1);
  localparam int unsigned CoordW   = $clog2(MaxDim);
  localparam int unsigned DistW    = DimW;
  localparam int unsigned SgnW     = DistW + 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 4;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    RegGridRows  = 2'd0,
    RegGridCols  = 2'd1,
    RegCenterRow = 2'd2,
    RegCenterCol = 2'd3
  } reg_idx_e;

  // Effective grid settings after clamping
  typedef struct packed {
    logic [DimW-1:0]   rows;
    logic [DimW-1:0]   cols;
    logic [CoordW-1:0] crow;
    logic [CoordW-1:0] ccol;
    logic [DistW-1:0]  maxd;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
    logic set_fin;
    logic rec;
    logic rec_exh;
    logic rec_last;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fin;
    logic over;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

// File: src/mrce_cfg.sv
// Configuration registers and clamped grid settings of the enumerator.
`default_nettype none

module mrce_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrce_pkg::AddrW-1:0] paddr,
  input  wire logic [mrce_pkg::DataW-1:0] pwdata,
  output logic      [mrce_pkg::DataW-1:0] prdata,
  output mrce_pkg::cfg_t                  cfg_o
);
  import mrce_pkg::*;

  logic [DimW-1:0]   rows_q, cols_q;
  logic [CoordW-1:0] crow_q, ccol_q;
  reg_idx_e          idx;
  logic              wr_en;
  logic [DimW-1:0]   rows_eff, cols_eff;
  logic [CoordW-1:0] cr_eff, cc_eff, rem_r, rem_c, far_r, far_c;
  cfg_t              cfg_d, cfg_q;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(1);
      cols_q <= DimW'(1);
      crow_q <= '0;
      ccol_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegGridRows:  rows_q <= pwdata[DimW-1:0];
        RegGridCols:  cols_q <= pwdata[DimW-1:0];
        RegCenterRow: crow_q <= pwdata[CoordW-1:0];
        RegCenterCol: ccol_q <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      RegGridRows:  prdata = {{(DataW-DimW){1'b0}}, rows_q};
      RegGridCols:  prdata = {{(DataW-DimW){1'b0}}, cols_q};
      RegCenterRow: prdata = {{(DataW-CoordW){1'b0}}, crow_q};
      RegCenterCol: prdata = {{(DataW-CoordW){1'b0}}, ccol_q};
      default:      prdata = '0;
    endcase
  end

  // Clamp the grid size and center, then find the farthest corner distance
  always_comb begin
    if (rows_q == '0)                rows_eff = DimW'(1);
    else if (rows_q > DimW'(MaxDim)) rows_eff = DimW'(MaxDim);
    else                             rows_eff = rows_q;
    if (cols_q == '0)                cols_eff = DimW'(1);
    else if (cols_q > DimW'(MaxDim)) cols_eff = DimW'(MaxDim);
    else                             cols_eff = cols_q;

    cr_eff = ({1'b0, crow_q} < rows_eff) ? crow_q : CoordW'(rows_eff - DimW'(1));
    cc_eff = ({1'b0, ccol_q} < cols_eff) ? ccol_q : CoordW'(cols_eff - DimW'(1));
    rem_r  = CoordW'(rows_eff - DimW'(1) - {1'b0, cr_eff});
    rem_c  = CoordW'(cols_eff - DimW'(1) - {1'b0, cc_eff});
    far_r  = (cr_eff > rem_r) ? cr_eff : rem_r;
    far_c  = (cc_eff > rem_c) ? cc_eff : rem_c;

    cfg_d.rows = rows_eff;
    cfg_d.cols = cols_eff;
    cfg_d.crow = cr_eff;
    cfg_d.ccol = cc_eff;
    cfg_d.maxd = DistW'({1'b0, far_r} + {1'b0, far_c});
  end

  // Register the derived settings computed from the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows <= DimW'(1);
      cfg_q.cols <= DimW'(1);
      cfg_q.crow <= '0;
      cfg_q.ccol <= '0;
      cfg_q.maxd <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/mrce_ctrl.sv
// Sequencing state machine of the enumerator: search, look-ahead and result handoff.
`default_nettype none

module mrce_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mrce_pkg::sts_t sts_i,
  output mrce_pkg::cmd_t      cmd_o
);
  import mrce_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StLook,
    StHold
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Decide the next step from the walk status
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (sts_i.fin) begin
          cmd_o.rec     = 1'b1;
          cmd_o.rec_exh = 1'b1;
          state_d       = StHold;
        end else if (sts_i.over) begin
          cmd_o.set_fin = 1'b1;
          cmd_o.rec     = 1'b1;
          cmd_o.rec_exh = 1'b1;
          state_d       = StHold;
        end else if (sts_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = StLook;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StLook: begin
        if (sts_i.over) begin
          cmd_o.rec      = 1'b1;
          cmd_o.rec_last = 1'b1;
          state_d        = StHold;
        end else if (sts_i.hit) begin
          cmd_o.rec = 1'b1;
          state_d   = StHold;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StHold: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  // A cell is committed only when it lies in the grid within the last ring
  a_commit_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (sts_i.hit && !sts_i.over && !sts_i.fin))
    else $error("commit without an in-grid candidate");

  // A recorded result is handed out before the next item is taken
  a_rec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rec |=> (state_q == StHold && !in_ready_o))
    else $error("recorded result not held");

endmodule

`default_nettype wire

// File: src/mrce_dp.sv
// Ring walk datapath: walk position, candidate generation, bounds check and result registers.
`default_nettype none

module mrce_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        restart_i,
  input  wire mrce_pkg::cfg_t              cfg_i,
  input  wire mrce_pkg::cmd_t              cmd_i,
  output mrce_pkg::sts_t                   sts_o,
  output logic      [mrce_pkg::CoordW-1:0] cell_row_o,
  output logic      [mrce_pkg::CoordW-1:0] cell_col_o,
  output logic      [mrce_pkg::DistW-1:0]  cell_distance_o,
  output logic                             is_last_o,
  output logic                             exhausted_o
);
  import mrce_pkg::*;

  // Candidate order within one ring
  typedef enum logic [2:0] {
    PosRight = 3'd0,
    PosLeft  = 3'd1,
    PosDnRt  = 3'd2,
    PosDnLt  = 3'd3,
    PosUpRt  = 3'd4,
    PosUpLt  = 3'd5,
    PosDown  = 3'd6,
    PosUp    = 3'd7
  } ring_pos_e;

  typedef struct packed {
    logic [DistW-1:0] d;
    logic [DistW-1:0] j;
    ring_pos_e        p;
  } walk_t;

  // Step to the next candidate of the walk
  function automatic walk_t adv(input walk_t w);
    walk_t n;
    n = w;
    if (w.d == '0) begin
      n.d = DistW'(1);
      n.j = '0;
      n.p = PosRight;
    end else begin
      case (w.p)
        PosRight: n.p = PosLeft;
        PosLeft: begin
          if (w.d > DistW'(1)) begin
            n.p = PosDnRt;
            n.j = DistW'(1);
          end else begin
            n.p = PosDown;
          end
        end
        PosDnRt: n.p = PosDnLt;
        PosDnLt: n.p = PosUpRt;
        PosUpRt: n.p = PosUpLt;
        PosUpLt: begin
          n.j = w.j + DistW'(1);
          n.p = (n.j < w.d) ? PosDnRt : PosDown;
        end
        PosDown: n.p = PosUp;
        default: begin
          n.d = w.d + DistW'(1);
          n.j = '0;
          n.p = PosRight;
        end
      endcase
    end
    return n;
  endfunction

  walk_t                   pos_q, scan_q, scan_adv;
  logic                    fin_q;
  logic signed [SgnW-1:0]  sd, sj, smj, dr, dc, cand_r, cand_c;
  logic                    in_r, in_c;
  logic [CoordW-1:0]       fnd_row_q, fnd_col_q;
  logic [DistW-1:0]        fnd_dist_q;
  logic                    res_exh_q, res_last_q;
  logic [CoordW-1:0]       out_row_q, out_col_q;
  logic [DistW-1:0]        out_dist_q;
  logic                    out_last_q, out_exh_q;

  assign scan_adv = adv(scan_q);

  // Form the candidate offset from the walk position
  always_comb begin
    sd  = $signed({2'b00, scan_q.d});
    sj  = $signed({2'b00, scan_q.j});
    smj = $signed({2'b00, DistW'(scan_q.d - scan_q.j)});
    dr  = '0;
    dc  = '0;
    if (scan_q.d != '0) begin
      case (scan_q.p)
        PosRight: dc = sd;
        PosLeft:  dc = -sd;
        PosDnRt: begin dr = sj;  dc = smj;  end
        PosDnLt: begin dr = sj;  dc = -smj; end
        PosUpRt: begin dr = -sj; dc = smj;  end
        PosUpLt: begin dr = -sj; dc = -smj; end
        PosDown:  dr = sd;
        default:  dr = -sd;
      endcase
    end
    cand_r = $signed({{(SgnW-CoordW){1'b0}}, cfg_i.crow}) + dr;
    cand_c = $signed({{(SgnW-CoordW){1'b0}}, cfg_i.ccol}) + dc;
    in_r   = !cand_r[SgnW-1] && (cand_r < $signed({{(SgnW-DimW){1'b0}}, cfg_i.rows}));
    in_c   = !cand_c[SgnW-1] && (cand_c < $signed({{(SgnW-DimW){1'b0}}, cfg_i.cols}));
  end

  assign sts_o.fin  = fin_q;
  assign sts_o.over = scan_q.d > cfg_i.maxd;
  assign sts_o.hit  = in_r && in_c;

  // Hold the committed walk position and the end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      scan_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_q <= restart_i ? walk_t'('0) : pos_q;
        if (restart_i) begin
          pos_q <= '0;
          fin_q <= 1'b0;
        end
      end else begin
        if (cmd_i.step || cmd_i.commit) scan_q <= scan_adv;
        if (cmd_i.commit)               pos_q  <= scan_adv;
        if (cmd_i.set_fin)              fin_q  <= 1'b1;
      end
    end
  end

  // Capture the found cell and the result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      fnd_row_q  <= cand_r[CoordW-1:0];
      fnd_col_q  <= cand_c[CoordW-1:0];
      fnd_dist_q <= scan_q.d;
    end
    if (cmd_i.rec) begin
      res_exh_q  <= cmd_i.rec_exh;
      res_last_q <= cmd_i.rec_last;
    end
  end

  // Load the output register; an exhausted result carries zero fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_exh_q  <= res_exh_q;
      out_row_q  <= res_exh_q ? '0 : fnd_row_q;
      out_col_q  <= res_exh_q ? '0 : fnd_col_q;
      out_dist_q <= res_exh_q ? '0 : fnd_dist_q;
      out_last_q <= res_exh_q ? 1'b0 : res_last_q;
    end
  end

  assign cell_row_o      = out_row_q;
  assign cell_col_o      = out_col_q;
  assign cell_distance_o = out_dist_q;
  assign is_last_o       = out_last_q;
  assign exhausted_o     = out_exh_q;

  // Inside a quadrant sweep the row offset stays strictly inside the ring
  a_offset_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((scan_q.p == PosDnRt || scan_q.p == PosDnLt || scan_q.p == PosUpRt ||
      scan_q.p == PosUpLt) && scan_q.d != '0)
      |-> (scan_q.j != '0 && scan_q.j < scan_q.d))
    else $error("row offset outside ring");

  // A restart puts the walk back on the center with the end flag clear
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && restart_i) |=> (pos_q == '0 && scan_q == '0 && !fin_q))
    else $error("restart did not clear the walk");

  // A committed candidate always lies inside the grid
  a_commit_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (in_r && in_c))
    else $error("committed cell outside grid");

endmodule

`default_nettype wire

// File: src/manhattan_ring_cell_enumerator_core.sv
// Top level of the Manhattan ring cell enumerator.
`default_nettype none

// Each request on the input channel returns one cell of the configured grid, walking
// outward from the center in rings of equal Manhattan distance: right, left, the four
// diagonal cells for each row offset, then down and up; cells outside the grid are
// skipped. A request with restart set begins again at the center. After the last cell
// (flagged by is_last) each request returns exhausted until a restart. The walk unit
// checks one ring candidate per cycle, first to find the cell and then to look ahead
// for the next one, so requests near edges and corners, where many candidates fall
// outside the grid, scan more candidates. Register writes reach the walk through the
// registered derived settings; grid sizes of zero count as one and the center is
// clamped into the grid. A finished result sits in an output register, and the next
// request is taken while it waits.
module manhattan_ring_cell_enumerator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mrce_pkg::AddrW-1:0]  paddr,
  input  wire logic [mrce_pkg::DataW-1:0]  pwdata,
  output logic      [mrce_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        restart_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [mrce_pkg::CoordW-1:0] cell_row_o,
  output logic      [mrce_pkg::CoordW-1:0] cell_col_o,
  output logic      [mrce_pkg::DistW-1:0]  cell_distance_o,
  output logic                             is_last_o,
  output logic                             exhausted_o
);
  import mrce_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // Configuration registers
  mrce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Sequencer
  mrce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Walk datapath
  mrce_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart_i),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cell_row_o      (cell_row_o),
    .cell_col_o      (cell_col_o),
    .cell_distance_o (cell_distance_o),
    .is_last_o       (is_last_o),
    .exhausted_o     (exhausted_o)
  );

endmodule

`default_nettype wire

// File: tb/ring_scan_checker.sv
// Checker for the ring cell enumerator: predicts each result and compares.
`timescale 1ns / 1ps

module ring_scan_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [mrce_pkg::AddrW-1:0]      paddr,
  input  logic [mrce_pkg::DataW-1:0]      pwdata,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic                            restart_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [mrce_pkg::CoordW-1:0]     cell_row_o,
  input  logic [mrce_pkg::CoordW-1:0]     cell_col_o,
  input  logic [mrce_pkg::DistW-1:0]      cell_distance_o,
  input  logic                            is_last_o,
  input  logic                            exhausted_o,
  output int unsigned                     cells_pending,
  output int unsigned                     mismatches
);

  import mrce_pkg::*;

  // Candidate order within one ring
  localparam logic [2:0] PosRight     = 3'd0;
  localparam logic [2:0] PosLeft      = 3'd1;
  localparam logic [2:0] PosDownRight = 3'd2;
  localparam logic [2:0] PosDownLeft  = 3'd3;
  localparam logic [2:0] PosUpRight   = 3'd4;
  localparam logic [2:0] PosUpLeft    = 3'd5;
  localparam logic [2:0] PosDown      = 3'd6;
  localparam logic [2:0] PosUp        = 3'd7;

  typedef struct packed {
    logic [DistW-1:0] ring;
    logic [DistW-1:0] offset;
    logic [2:0]       pos;
  } walk_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [DistW-1:0]  distance;
    logic              last;
    logic              exhausted;
  } cell_result_t;

  logic [DimW-1:0]   grid_rows;
  logic [DimW-1:0]   grid_cols;
  logic [CoordW-1:0] center_row;
  logic [CoordW-1:0] center_col;
  walk_t             walk;
  logic              walk_done;
  cell_result_t      cells_due[$];

  function automatic int clamp_dim(input logic [DimW-1:0] v);
    int d;
    d = int'(v);
    if (d < 1) d = 1;
    if (d > int'(MaxDim)) d = int'(MaxDim);
    return d;
  endfunction

  // Move to the next candidate of the ring walk
  function automatic walk_t advance_walk(input walk_t w);
    walk_t n;
    n = w;
    if (w.ring == '0) begin
      n.ring = DistW'(1);
      n.offset = '0;
      n.pos = PosRight;
    end else begin
      case (w.pos)
        PosRight: n.pos = PosLeft;
        PosLeft: begin
          if (w.ring > DistW'(1)) begin
            n.pos = PosDownRight;
            n.offset = DistW'(1);
          end else begin
            n.pos = PosDown;
          end
        end
        PosDownRight, PosDownLeft, PosUpRight: n.pos = w.pos + 3'd1;
        PosUpLeft: begin
          n.offset = w.offset + DistW'(1);
          n.pos = (n.offset < w.ring) ? PosDownRight : PosDown;
        end
        PosDown: n.pos = PosUp;
        default: begin
          n.ring = w.ring + DistW'(1);
          n.offset = '0;
          n.pos = PosRight;
        end
      endcase
    end
    return n;
  endfunction

  // Scan from a walk position for the next candidate inside the grid
  function automatic logic find_cell(input walk_t from, input int rows, input int cols,
                                     input int crow, input int ccol, input int maxd,
                                     output walk_t past, output int row, output int col);
    walk_t w;
    int d, j, dr, dc, r, c;
    logic hit;
    w = from;
    hit = 1'b0;
    row = 0;
    col = 0;
    while (!hit && int'(w.ring) <= maxd) begin
      d = int'(w.ring);
      j = int'(w.offset);
      dr = 0;
      dc = 0;
      if (d != 0) begin
        case (w.pos)
          PosRight:     begin dr = 0;  dc = d;        end
          PosLeft:      begin dr = 0;  dc = -d;       end
          PosDownRight: begin dr = j;  dc = d - j;    end
          PosDownLeft:  begin dr = j;  dc = -(d - j); end
          PosUpRight:   begin dr = -j; dc = d - j;    end
          PosUpLeft:    begin dr = -j; dc = -(d - j); end
          PosDown:      begin dr = d;  dc = 0;        end
          default:      begin dr = -d; dc = 0;        end
        endcase
      end
      r = crow + dr;
      c = ccol + dc;
      w = advance_walk(w);
      if (r >= 0 && r < rows && c >= 0 && c < cols) begin
        hit = 1'b1;
        row = r;
        col = c;
      end
    end
    past = w;
    return hit;
  endfunction

  // Work out the cell that one request returns and queue it
  task automatic predict_next_cell(input logic restart);
    int rows, cols, crow, ccol, maxd, row, col, look_row, look_col, span;
    walk_t past, ahead;
    cell_result_t entry;
    logic more;
    rows = clamp_dim(grid_rows);
    cols = clamp_dim(grid_cols);
    crow = (int'(center_row) < rows) ? int'(center_row) : rows - 1;
    ccol = (int'(center_col) < cols) ? int'(center_col) : cols - 1;
    maxd = ((crow > rows - 1 - crow) ? crow : rows - 1 - crow)
         + ((ccol > cols - 1 - ccol) ? ccol : cols - 1 - ccol);
    entry = '0;
    if (restart) begin
      walk = '0;
      walk_done = 1'b0;
    end
    if (walk_done) begin
      entry.exhausted = 1'b1;
    end else if (!find_cell(walk, rows, cols, crow, ccol, maxd, past, row, col)) begin
      walk_done = 1'b1;
      entry.exhausted = 1'b1;
    end else begin
      walk = past;
      more = find_cell(past, rows, cols, crow, ccol, maxd, ahead, look_row, look_col);
      span = ((row > crow) ? row - crow : crow - row)
           + ((col > ccol) ? col - ccol : ccol - col);
      entry.row = row[CoordW-1:0];
      entry.col = col[CoordW-1:0];
      entry.distance = span[DistW-1:0];
      entry.last = !more;
    end
    cells_due.insert(cells_due.size(), entry);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one result transfer with the oldest queued cell
  task automatic check_cell();
    cell_result_t want;
    if (cells_due.size() == 0) begin
      report_mismatch($sformatf("unrequested result row %0d col %0d exhausted %0b",
                                cell_row_o, cell_col_o, exhausted_o));
      return;
    end
    want = cells_due.pop_front();
    if (cell_row_o !== want.row)
      report_mismatch($sformatf("cell_row %0d, want %0d", cell_row_o, want.row));
    if (cell_col_o !== want.col)
      report_mismatch($sformatf("cell_col %0d, want %0d", cell_col_o, want.col));
    if (cell_distance_o !== want.distance)
      report_mismatch($sformatf("cell_distance %0d, want %0d", cell_distance_o,
                                want.distance));
    if (is_last_o !== want.last)
      report_mismatch($sformatf("is_last %0b, want %0b", is_last_o, want.last));
    if (exhausted_o !== want.exhausted)
      report_mismatch($sformatf("exhausted %0b, want %0b", exhausted_o, want.exhausted));
  endtask

  // Track register writes, check results, predict requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows = 1;
      grid_cols = 1;
      center_row = '0;
      center_col = '0;
      walk = '0;
      walk_done = 1'b0;
      cells_due.delete();
      cells_pending = 0;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          RegGridRows:  grid_rows = pwdata[DimW-1:0];
          RegGridCols:  grid_cols = pwdata[DimW-1:0];
          RegCenterRow: center_row = pwdata[CoordW-1:0];
          default:      center_col = pwdata[CoordW-1:0];
        endcase
      end
      if (out_valid_o && out_ready_i) check_cell();
      if (in_valid_i && in_ready_o) predict_next_cell(restart_i);
      cells_pending = cells_due.size();
    end
  end

endmodule

// File: tb/manhattan_ring_cell_enumerator_core_test.sv
// Testbench top for the ring cell enumerator: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module manhattan_ring_cell_enumerator_core_test;

  import mrce_pkg::*;

  localparam int unsigned TotalItems = 1900;
  // Cycle limit for the whole run, allowing for requests that scan outer rings and for output stalls
  localparam int unsigned CycleLimit = 60000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                restart_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CoordW-1:0]   cell_row_o;
  logic [CoordW-1:0]   cell_col_o;
  logic [DistW-1:0]    cell_distance_o;
  logic                is_last_o;
  logic                exhausted_o;
  int unsigned         cells_pending;
  int unsigned         mismatches;
  int unsigned         requests_sent = 0;
  int unsigned         cycle_count = 0;
  int unsigned         ready_gap;
  int unsigned         burst;

  manhattan_ring_cell_enumerator_core DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .restart_i, .out_valid_o, .out_ready_i,
    .cell_row_o, .cell_col_o, .cell_distance_o, .is_last_o, .exhausted_o
  );

  ring_scan_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_ready_o, .restart_i, .out_valid_o, .out_ready_i,
    .cell_row_o, .cell_col_o, .cell_distance_o, .is_last_o, .exhausted_o,
    .cells_pending, .mismatches
  );

  // Run the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a run that never finishes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One register write: setup cycle, access cycle, then release the bus
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a grid shape and center, covering strips, clamping and oversize
  task automatic configure_grid();
    int unsigned       shape;
    int unsigned       roll;
    logic [DimW-1:0]   rows;
    logic [DimW-1:0]   cols;
    logic [CoordW-1:0] crow;
    logic [CoordW-1:0] ccol;
    shape = $urandom_range(0, 6);
    case (shape)
      0: begin
        rows = DimW'($urandom_range(1, 5));
        cols = DimW'($urandom_range(1, 5));
      end
      1: begin
        rows = DimW'(1);
        cols = DimW'($urandom_range(1, 256));
      end
      2: begin
        rows = DimW'($urandom_range(2, 256));
        cols = DimW'($urandom_range(1, 2));
      end
      3: begin
        rows = DimW'($urandom_range(200, 256));
        cols = DimW'($urandom_range(200, 256));
      end
      4: begin
        rows = ($urandom_range(0, 1) == 0) ? '0 : DimW'($urandom_range(257, 511));
        cols = DimW'($urandom_range(0, 511));
      end
      default: begin
        rows = DimW'($urandom_range(1, 64));
        cols = DimW'($urandom_range(1, 64));
      end
    endcase
    roll = $urandom_range(0, 3);
    if (roll == 0)      crow = '0;
    else if (roll == 1) crow = '1;
    else                crow = CoordW'($urandom_range(0, (rows > DimW'(1)) ? rows - 1 : 0));
    roll = $urandom_range(0, 3);
    if (roll == 0)      ccol = '0;
    else if (roll == 1) ccol = '1;
    else                ccol = CoordW'($urandom_range(0, (cols > DimW'(1)) ? cols - 1 : 0));
    write_reg(RegGridRows, DataW'(rows));
    write_reg(RegGridCols, DataW'(cols));
    write_reg(RegCenterRow, DataW'(crow));
    write_reg(RegCenterCol, DataW'(ccol));
  endtask

  // Send a burst of requests, restarting now and then
  task automatic send_items(input int unsigned count);
    int unsigned gap;
    logic        restart;
    for (int unsigned k = 0; k < count; k++) begin
      gap = pick_gap();
      if (k == 0) restart = ($urandom_range(0, 1) == 1);
      else        restart = ($urandom_range(0, 19) == 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      restart_i  <= restart;
      do @(posedge clk_i); while (!in_ready_o);
      requests_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  // Wait until every accepted request has had its result transferred
  task automatic wait_drained();
    do @(posedge clk_i); while (cells_pending != 0);
  endtask

  // Toggle output ready with random stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      ready_gap = pick_gap();
      if (ready_gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (ready_gap) @(posedge clk_i);
      end
    end
  end

  // Reset, then alternate register setup and request bursts
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (requests_sent < TotalItems) begin
      configure_grid();
      burst = $urandom_range(8, 160);
      if (burst > TotalItems - requests_sent) burst = TotalItems - requests_sent;
      send_items(burst);
      wait_drained();
    end
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) $display("*** PASSED ***");
    else                 $display("*** FAILED ***");
    $finish;
  end

endmodule
